[design/pngunf_pkg.sv]
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types, constants and predictor functions for the PNG scanline
// unfilter (filter method 0).
// ----------------------------------------------------------------------------
package pngunf_pkg;

   localparam int MAX_LINE_BYTES  = 8192;
   localparam int MAX_PIXEL_BYTES = 8;

   localparam int BYTE_W    = 8;
   localparam int BPP_W     = 4;
   localparam int LINE_W    = 14;
   localparam int CSR_DATA_W = 14;
   localparam int ADDR_W    = $clog2(MAX_LINE_BYTES);
   localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   localparam logic [BPP_W-1:0]  BPP_RESET  = BPP_W'(4);
   localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(4);

   typedef enum logic [0:0] {
      CSR_BPP  = 1'b0,
      CSR_LINE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   function automatic logic [10:0] abs11(input logic signed [10:0] v);
      return (v < 0) ? 11'(-v) : 11'(v);
   endfunction

   // Paeth predictor: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
   function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic [10:0] pa;
      logic [10:0] pb;
      logic [10:0] pc;
      pa = abs11($signed({3'b000, b}) - $signed({3'b000, c}));
      pb = abs11($signed({3'b000, a}) - $signed({3'b000, c}));
      pc = abs11($signed({3'b000, a}) + $signed({3'b000, b})
                 - $signed({2'b00, c, 1'b0}));
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

endpackage

[design/png_scanline_unfilter_top.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG filter method 0 reconstruction (None, Sub, Up, Average, Paeth), one
// byte per item, with the previous row held in an on-chip line store.
// ----------------------------------------------------------------------------
//  channel  dir  tdata             tuser          tlast
//  req_     in   [7:0] data_byte   [0] image_start  -
//  rsp_     out  [7:0] out_byte    [0] filter_error [0] row_last
//  csr_     in   index 0 bytes_per_pixel, index 1 line_bytes (write only)
//
// One item per clock unless stalled; result appears in the output register the
// cycle after the item is accepted. The line store read for the next data byte
// is issued in the cycle the current item is taken, so the single registered
// RAM read port closes the loop. Valid filter-type bytes give no result, a bad
// one an error item. Reset clears control state only; the line store is not
// cleared. A stalled result holds req_tready low until it is taken.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] data_byte
   input  logic [0:0]                   req_tuser,   // [0] image_start
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast,   // row_last
   output logic [0:0]                   rsp_tuser,   // [0] filter_error
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  pngunf_pkg::csr_index_type    csr_index,
   input  logic [pngunf_pkg::CSR_DATA_W-1:0] csr_data
);
   import pngunf_pkg::*;

   // configuration
   logic [BPP_W-1:0]  bpp_ff;
   logic [LINE_W-1:0] line_ff;

   // row state
   logic [LINE_W-1:0] pos_ff, pos_in;
   filter_type        filter_ff, filter_in;
   logic              first_ff, first_in;
   logic              expect_ff, expect_in;
   logic              err_ff, err_in;
   logic [7:0]        left_ff [MAX_PIXEL_BYTES];
   logic [7:0]        upleft_ff [MAX_PIXEL_BYTES];

   // line store
   logic [7:0]        row_mem [MAX_LINE_BYTES];
   logic [7:0]        up_rd_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              wr_en;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              accept;
   logic              start, expect_eff, first_eff, hold_eff;
   logic              row_clear, data_step, bad_filter;
   logic [7:0]        x, a, b, c, r;
   logic [PIX_IDX_W-1:0] tap;
   logic [LINE_W-1:0] line_eff;
   logic              last;
   logic [8:0]        ab_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff  <= BPP_RESET;
         line_ff <= LINE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BPP:  bpp_ff  <= csr_data[BPP_W-1:0];
            CSR_LINE: line_ff <= csr_data[LINE_W-1:0];
            default:  ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign x          = req_tdata;
   assign start      = req_tuser[0];
   assign expect_eff = start || expect_ff;
   assign first_eff  = start || first_ff;
   assign hold_eff   = !start && err_ff;

   assign bad_filter = accept && !hold_eff && expect_eff && (x > 8'(FILT_PAETH));
   assign row_clear  = accept && !hold_eff && expect_eff;
   assign data_step  = accept && !hold_eff && !expect_eff;

   // clamp the two configuration values to their legal ranges
   always_comb begin
      if (bpp_ff == '0) begin
         tap = '0;
      end else if (bpp_ff > BPP_W'(MAX_PIXEL_BYTES)) begin
         tap = PIX_IDX_W'(MAX_PIXEL_BYTES - 1);
      end else begin
         tap = PIX_IDX_W'(bpp_ff - BPP_W'(1));
      end
      if (line_ff == '0) begin
         line_eff = LINE_W'(1);
      end else if (line_ff > LINE_W'(MAX_LINE_BYTES)) begin
         line_eff = LINE_W'(MAX_LINE_BYTES);
      end else begin
         line_eff = line_ff;
      end
   end

   assign a      = left_ff[tap];
   assign c      = upleft_ff[tap];
   assign b      = first_ff ? 8'd0 : up_rd_ff;
   assign ab_sum = {1'b0, a} + {1'b0, b};
   assign last   = ({1'b0, pos_ff} + 15'd1) >= {1'b0, line_eff};

   always_comb begin
      case (filter_ff)
         FILT_SUB:   r = x + a;
         FILT_UP:    r = x + b;
         FILT_AVG:   r = x + ab_sum[8:1];
         FILT_PAETH: r = x + paeth_pred(a, b, c);
         default:    r = x;
      endcase
   end

   // next row state
   always_comb begin
      pos_in    = pos_ff;
      filter_in = filter_ff;
      first_in  = first_ff;
      expect_in = expect_ff;
      err_in    = err_ff;
      if (row_clear) begin
         pos_in   = '0;
         first_in = first_eff;
         if (bad_filter) begin
            err_in    = 1'b1;
            expect_in = 1'b1;
         end else begin
            err_in    = 1'b0;
            expect_in = 1'b0;
            filter_in = filter_type'(x[2:0]);
         end
      end else if (data_step) begin
         if (last) begin
            pos_in    = '0;
            expect_in = 1'b1;
            first_in  = 1'b0;
         end else begin
            pos_in = pos_ff + LINE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filter_ff <= FILT_NONE;
         first_ff  <= 1'b1;
         expect_ff <= 1'b1;
         err_ff    <= 1'b0;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         filter_ff <= filter_in;
         first_ff  <= first_in;
         expect_ff <= expect_in;
         err_ff    <= err_in;
         if (row_clear) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
               left_ff[i]   <= '0;
               upleft_ff[i] <= '0;
            end
         end else if (data_step) begin
            left_ff[0]   <= r;
            upleft_ff[0] <= b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
               left_ff[i]   <= left_ff[i-1];
               upleft_ff[i] <= upleft_ff[i-1];
            end
         end
      end
   end

   // line store: read runs one item ahead at the next byte position;
   // a same-address write in that cycle is forwarded (one-byte rows)
   assign wr_en   = data_step;
   assign wr_addr = pos_ff[ADDR_W-1:0];
   assign rd_addr = pos_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= r;
      end
      if (wr_en && wr_addr == rd_addr) begin
         up_rd_ff <= r;
      end else begin
         up_rd_ff <= row_mem[rd_addr];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (bad_filter) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = 8'd0;
         rsp_last_in  = 1'b0;
         rsp_err_in   = 1'b1;
      end else if (data_step) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = r;
         rsp_last_in  = last;
         rsp_err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_byte_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule

[design/pngunf_check.sv]
// ----------------------------------------------------------------------------
// pngunf_check
// Port-level checks for the PNG scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module pngunf_check (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // error item carries a zero byte and never closes a row
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0 && !rsp_tlast)
      else $error("bad error item");

   // a stalled result blocks the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken over a stalled result");

   // nothing comes out right after reset
   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind png_scanline_unfilter_top pngunf_check u_pngunf_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
